[design/spma_pkg.sv]
// Shared constants and types of the sparse polynomial merge adder.
`default_nettype none
package spma_pkg;

  localparam int MAX_TERMS = 32;
  localparam int COEFF_W   = 16;
  localparam int POWER_W   = 16;
  localparam int RES_W     = COEFF_W + 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_ADD    = 2'd2;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [POWER_W-1:0]        power;
  } term_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    term_t             data;
  } store_wr_t;

endpackage
`default_nettype wire

[design/sparse_polynomial_merge_add_core.sv]
// Top level of the sparse polynomial merge adder.
//
//   Channel | Handshake            | Payload
//   in      | in_valid / in_ready  | operation, coefficient, exponent
//   out     | out_valid / out_ready| result_coeff, result_power, term_valid, last_term, overflow
//
// A load request writes one term into term memory A or B. An add request walks both
// term memories one merge step per cycle while the merge is not stalled, and takes a
// pair of equal powers in a single step. Each emitted term is held one step in a pending
// register until the next term is known, so the final term can be marked. The merge
// stalls while the output register is full, and no request is taken while an add runs.
// Reset is synchronous and active low; the memories themselves are not cleared.
`default_nettype none
module sparse_polynomial_merge_add_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [1:0]                         in_operation,
  input  wire signed [spma_pkg::COEFF_W-1:0] in_coefficient,
  input  wire [spma_pkg::POWER_W-1:0]       in_exponent,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [spma_pkg::RES_W-1:0] out_result_coeff,
  output logic [spma_pkg::POWER_W-1:0]      out_result_power,
  output logic                              out_term_valid,
  output logic                              out_last_term,
  output logic                              out_overflow
);

  spma_pkg::store_wr_t               wr_a, wr_b;
  logic [spma_pkg::ADDR_W-1:0]       rd_addr_a, rd_addr_b;
  spma_pkg::term_t                   rd_a, rd_b;

  spma_store u_store_a (
    .clk     (clk),
    .wr      (wr_a),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  spma_store u_store_b (
    .clk     (clk),
    .wr      (wr_b),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  spma_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_coefficient   (in_coefficient),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_coeff (out_result_coeff),
    .out_result_power (out_result_power),
    .out_term_valid   (out_term_valid),
    .out_last_term    (out_last_term),
    .out_overflow     (out_overflow),
    .wr_a             (wr_a),
    .wr_b             (wr_b),
    .rd_addr_a        (rd_addr_a),
    .rd_addr_b        (rd_addr_b),
    .rd_a             (rd_a),
    .rd_b             (rd_b)
  );

endmodule
`default_nettype wire

[design/spma_store.sv]
// Term store: one synchronous memory with one write port and one registered read port.
`default_nettype none
module spma_store (
  input  wire                           clk,
  input  spma_pkg::store_wr_t           wr,
  input  wire [spma_pkg::ADDR_W-1:0]    rd_addr,
  output spma_pkg::term_t               rd_data
);

  spma_pkg::term_t mem_r [spma_pkg::MAX_TERMS];
  spma_pkg::term_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[design/spma_merge.sv]
// Load control, merge sequencer, pending term and output register.
`default_nettype none
module spma_merge (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [1:0]                         in_operation,
  input  wire signed [spma_pkg::COEFF_W-1:0] in_coefficient,
  input  wire [spma_pkg::POWER_W-1:0]       in_exponent,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [spma_pkg::RES_W-1:0] out_result_coeff,
  output logic [spma_pkg::POWER_W-1:0]      out_result_power,
  output logic                              out_term_valid,
  output logic                              out_last_term,
  output logic                              out_overflow,
  output spma_pkg::store_wr_t               wr_a,
  output spma_pkg::store_wr_t               wr_b,
  output logic [spma_pkg::ADDR_W-1:0]       rd_addr_a,
  output logic [spma_pkg::ADDR_W-1:0]       rd_addr_b,
  input  spma_pkg::term_t                   rd_a,
  input  spma_pkg::term_t                   rd_b
);

  typedef enum logic {ST_IDLE, ST_MERGE} state_t;

  state_t state_r, state_nxt;
  logic [spma_pkg::CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [spma_pkg::CNT_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic flag_r, flag_nxt;
  logic pend_valid_r, pend_valid_nxt;
  logic signed [spma_pkg::RES_W-1:0] pend_coeff_r, pend_coeff_nxt;
  logic [spma_pkg::POWER_W-1:0] pend_power_r, pend_power_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [spma_pkg::RES_W-1:0] out_coeff_r, out_coeff_nxt;
  logic [spma_pkg::POWER_W-1:0] out_power_r, out_power_nxt;
  logic out_tv_r, out_tv_nxt, out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;

  logic a_more, b_more, have_term, adv_a, adv_b, out_free;
  logic signed [spma_pkg::RES_W-1:0] term_coeff, sum;
  logic [spma_pkg::POWER_W-1:0] term_power;

  assign a_more   = ia_r < cnt_a_r;
  assign b_more   = ib_r < cnt_b_r;
  assign out_free = !out_valid_r || out_ready;
  assign sum      = spma_pkg::RES_W'(rd_a.coeff) + spma_pkg::RES_W'(rd_b.coeff);

  always_comb begin
    have_term  = 1'b0;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    term_coeff = spma_pkg::RES_W'(rd_a.coeff);
    term_power = rd_a.power;
    if (a_more && b_more) begin
      if (rd_a.power > rd_b.power) begin
        have_term = 1'b1;
        adv_a     = 1'b1;
      end else if (rd_a.power < rd_b.power) begin
        have_term  = 1'b1;
        adv_b      = 1'b1;
        term_coeff = spma_pkg::RES_W'(rd_b.coeff);
        term_power = rd_b.power;
      end else begin
        have_term  = (sum != '0);
        adv_a      = 1'b1;
        adv_b      = 1'b1;
        term_coeff = sum;
      end
    end else if (a_more) begin
      have_term = 1'b1;
      adv_a     = 1'b1;
    end else if (b_more) begin
      have_term  = 1'b1;
      adv_b      = 1'b1;
      term_coeff = spma_pkg::RES_W'(rd_b.coeff);
      term_power = rd_b.power;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    flag_nxt       = flag_r;
    pend_valid_nxt = pend_valid_r;
    pend_coeff_nxt = pend_coeff_r;
    pend_power_nxt = pend_power_r;
    out_valid_nxt  = out_valid_r;
    out_coeff_nxt  = out_coeff_r;
    out_power_nxt  = out_power_r;
    out_tv_nxt     = out_tv_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    wr_a           = '0;
    wr_b           = '0;
    wr_a.addr      = cnt_a_r[spma_pkg::ADDR_W-1:0];
    wr_b.addr      = cnt_b_r[spma_pkg::ADDR_W-1:0];
    wr_a.data      = '{coeff: in_coefficient, power: in_exponent};
    wr_b.data      = '{coeff: in_coefficient, power: in_exponent};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            spma_pkg::OP_LOAD_A: begin
              if (cnt_a_r == spma_pkg::CNT_W'(spma_pkg::MAX_TERMS)) begin
                flag_nxt = 1'b1;
              end else begin
                wr_a.we   = 1'b1;
                cnt_a_nxt = cnt_a_r + spma_pkg::CNT_W'(1);
              end
            end
            spma_pkg::OP_LOAD_B: begin
              if (cnt_b_r == spma_pkg::CNT_W'(spma_pkg::MAX_TERMS)) begin
                flag_nxt = 1'b1;
              end else begin
                wr_b.we   = 1'b1;
                cnt_b_nxt = cnt_b_r + spma_pkg::CNT_W'(1);
              end
            end
            spma_pkg::OP_ADD: begin
              state_nxt      = ST_MERGE;
              pend_valid_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (a_more || b_more) begin
          if (!have_term) begin
            ia_nxt = ia_r + spma_pkg::CNT_W'(adv_a);
            ib_nxt = ib_r + spma_pkg::CNT_W'(adv_b);
          end else if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_coeff_nxt = pend_coeff_r;
              out_power_nxt = pend_power_r;
              out_tv_nxt    = 1'b1;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = flag_r;
            end
            pend_valid_nxt = 1'b1;
            pend_coeff_nxt = term_coeff;
            pend_power_nxt = term_power;
            ia_nxt         = ia_r + spma_pkg::CNT_W'(adv_a);
            ib_nxt         = ib_r + spma_pkg::CNT_W'(adv_b);
          end
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_coeff_nxt  = pend_valid_r ? pend_coeff_r : '0;
          out_power_nxt  = pend_valid_r ? pend_power_r : '0;
          out_tv_nxt     = pend_valid_r;
          out_last_nxt   = 1'b1;
          out_ovf_nxt    = flag_r;
          pend_valid_nxt = 1'b0;
          flag_nxt       = 1'b0;
          cnt_a_nxt      = '0;
          cnt_b_nxt      = '0;
          ia_nxt         = '0;
          ib_nxt         = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      flag_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      flag_r       <= flag_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_coeff_r <= pend_coeff_nxt;
    pend_power_r <= pend_power_nxt;
    out_coeff_r  <= out_coeff_nxt;
    out_power_r  <= out_power_nxt;
    out_tv_r     <= out_tv_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign rd_addr_a        = ia_nxt[spma_pkg::ADDR_W-1:0];
  assign rd_addr_b        = ib_nxt[spma_pkg::ADDR_W-1:0];
  assign out_valid        = out_valid_r;
  assign out_result_coeff = out_coeff_r;
  assign out_result_power = out_power_r;
  assign out_term_valid   = out_tv_r;
  assign out_last_term    = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule
`default_nettype wire

[bench/spma_sum_check.sv]
// Channel monitor for the merge adder: predicts every sum term and compares it.
module spma_sum_check
  import spma_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire                      in_ready,
  input  wire [1:0]                in_operation,
  input  wire signed [COEFF_W-1:0] in_coefficient,
  input  wire [POWER_W-1:0]        in_exponent,
  input  wire                      out_valid,
  input  wire                      out_ready,
  input  wire signed [RES_W-1:0]   out_result_coeff,
  input  wire [POWER_W-1:0]        out_result_power,
  input  wire                      out_term_valid,
  input  wire                      out_last_term,
  input  wire                      out_overflow,
  output int                       fail_count,
  output int                       terms_waiting,
  output int                       terms_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [RES_W-1:0] coeff;
    logic [POWER_W-1:0]      power;
    logic                    live;
    logic                    last;
    logic                    ovf;
  } sum_term_t;

  term_t       poly_a [MAX_TERMS];
  term_t       poly_b [MAX_TERMS];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  logic        dropped = 1'b0;
  sum_term_t   expected_terms[$];
  int          mismatches = 0;
  int          compared = 0;

  assign fail_count    = mismatches;
  assign terms_checked = compared;

  initial terms_waiting = 0;

  task automatic predict_sum();
    sum_term_t               merged[$];
    sum_term_t               t;
    int unsigned             ia;
    int unsigned             ib;
    logic signed [RES_W-1:0] ca;
    logic signed [RES_W-1:0] cb;
    logic signed [RES_W-1:0] c;
    logic [POWER_W-1:0]      p;
    logic                    keep;
    ia = 0;
    ib = 0;
    while (ia < len_a || ib < len_b) begin
      keep = 1'b1;
      if (ia < len_a && (ib >= len_b || poly_a[ia].power > poly_b[ib].power)) begin
        c = poly_a[ia].coeff;
        p = poly_a[ia].power;
        ia++;
      end else if (ib < len_b && (ia >= len_a || poly_b[ib].power > poly_a[ia].power)) begin
        c = poly_b[ib].coeff;
        p = poly_b[ib].power;
        ib++;
      end else begin
        ca = poly_a[ia].coeff;
        cb = poly_b[ib].coeff;
        c = ca + cb;
        p = poly_a[ia].power;
        keep = (c != 0);
        ia++;
        ib++;
      end
      if (keep) begin
        t.coeff = c;
        t.power = p;
        t.live  = 1'b1;
        t.last  = 1'b0;
        t.ovf   = dropped;
        merged.push_back(t);
      end
    end
    if (merged.size() == 0) begin
      t.coeff = '0;
      t.power = '0;
      t.live  = 1'b0;
      t.last  = 1'b0;
      t.ovf   = dropped;
      merged.push_back(t);
    end
    merged[merged.size()-1].last = 1'b1;
    foreach (merged[i]) expected_terms.push_back(merged[i]);
    len_a = 0;
    len_b = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    sum_term_t want;
    if (!rst_n) begin
      len_a = 0;
      len_b = 0;
      dropped = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_operation)
          OP_LOAD_A: begin
            if (len_a < MAX_TERMS) begin
              poly_a[len_a] = '{coeff: in_coefficient, power: in_exponent};
              len_a++;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_LOAD_B: begin
            if (len_b < MAX_TERMS) begin
              poly_b[len_b] = '{coeff: in_coefficient, power: in_exponent};
              len_b++;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_ADD: predict_sum();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_terms.size() == 0) begin
          $error("unexpected sum term: coeff %0d power %0d", out_result_coeff,
                 out_result_power);
          mismatches++;
        end else begin
          want = expected_terms.pop_front();
          if (out_result_coeff !== want.coeff) begin
            $error("result_coeff: expected %0d, actual %0d", want.coeff, out_result_coeff);
            mismatches++;
          end
          if (out_result_power !== want.power) begin
            $error("result_power: expected %0d, actual %0d", want.power, out_result_power);
            mismatches++;
          end
          if (out_term_valid !== want.live) begin
            $error("term_valid: expected %0d, actual %0d", want.live, out_term_valid);
            mismatches++;
          end
          if (out_last_term !== want.last) begin
            $error("last_term: expected %0d, actual %0d", want.last, out_last_term);
            mismatches++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow: expected %0d, actual %0d", want.ovf, out_overflow);
            mismatches++;
          end
          compared++;
        end
      end
    end
    terms_waiting = expected_terms.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top: drives requests into the merge adder and reports the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spma_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};
  localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic [POWER_W-1:0] POWER_MAX = '1;
  localparam int REQUEST_TARGET = 420;
  localparam int LONG_HOLD = 250;
  localparam int SETTLE = 40;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                in_operation;
  logic signed [COEFF_W-1:0] in_coefficient;
  logic [POWER_W-1:0]        in_exponent;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [RES_W-1:0]   out_result_coeff;
  logic [POWER_W-1:0]        out_result_power;
  logic                      out_term_valid;
  logic                      out_last_term;
  logic                      out_overflow;

  int fail_count;
  int terms_waiting;
  int terms_checked;
  int requests_sent = 0;
  int adds_sent = 0;
  int full_store_adds = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit long_hold = 1'b0;

  sparse_polynomial_merge_add_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_coefficient(in_coefficient),
    .in_exponent(in_exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_coeff(out_result_coeff), .out_result_power(out_result_power),
    .out_term_valid(out_term_valid), .out_last_term(out_last_term),
    .out_overflow(out_overflow)
  );

  spma_sum_check sum_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_coefficient(in_coefficient),
    .in_exponent(in_exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_coeff(out_result_coeff), .out_result_power(out_result_power),
    .out_term_valid(out_term_valid), .out_last_term(out_last_term),
    .out_overflow(out_overflow),
    .fail_count(fail_count), .terms_waiting(terms_waiting),
    .terms_checked(terms_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(logic [1:0] op, logic signed [COEFF_W-1:0] coeff,
                              logic [POWER_W-1:0] power);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_coefficient <= coeff;
    in_exponent    <= power;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == OP_ADD) adds_sent++;
    if (op != OP_NONE) requests_sent++;
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (terms_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic signed [COEFF_W-1:0] random_coeff();
    case ($urandom_range(0, 9))
      0: return COEFF_MIN;
      1: return COEFF_MAX;
      2: return '0;
      3, 4: return COEFF_W'(int'($urandom_range(0, 20)) - 10);
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 5);
    if (r < 17) return $urandom_range(6, 20);
    if (r < 19) return $urandom_range(28, MAX_TERMS);
    return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3);
  endfunction

  // Builds two term lists with descending powers (or random ones when scrambled),
  // loads them interleaved with stray ignored requests, then requests the add.
  task automatic play_sums(int want_a, int want_b, bit scramble, bit hold_results);
    term_t                     qa[$];
    term_t                     qb[$];
    term_t                     t;
    int                        p;
    int                        rem;
    int                        pick;
    logic signed [COEFF_W-1:0] ca;
    p = ($urandom_range(0, 3) == 0) ? int'(POWER_MAX) : $urandom_range(100, POWER_MAX);
    while (qa.size() < want_a || qb.size() < want_b) begin
      rem = want_a - qa.size() + want_b - qb.size();
      if (scramble) p = $urandom_range(0, POWER_MAX);
      if (qa.size() == want_a) pick = 1;
      else if (qb.size() == want_b) pick = 0;
      else pick = $urandom_range(0, 2);
      ca = random_coeff();
      if (pick != 1) qa.push_back('{coeff: ca, power: POWER_W'(p)});
      if (pick != 0) begin
        if (pick == 2 && $urandom_range(0, 2) == 0 && ca != COEFF_MIN) ca = -ca;
        else if (pick == 2) ca = random_coeff();
        qb.push_back('{coeff: ca, power: POWER_W'(p)});
      end
      if (!scramble) p -= 1 + $urandom_range(0, (p - rem + 1) / rem);
    end
    if (want_a > MAX_TERMS || want_b > MAX_TERMS) full_store_adds++;
    while (qa.size() != 0 || qb.size() != 0) begin
      if (qa.size() != 0 && (qb.size() == 0 || $urandom_range(0, 1) == 1)) begin
        t = qa.pop_front();
        send_request(OP_LOAD_A, t.coeff, t.power);
      end else begin
        t = qb.pop_front();
        send_request(OP_LOAD_B, t.coeff, t.power);
      end
      if ($urandom_range(0, 11) == 0) begin
        send_request(OP_NONE, COEFF_W'($urandom), POWER_W'($urandom));
      end
    end
    if (hold_results) long_hold = 1'b1;
    send_request(OP_ADD, COEFF_W'($urandom), POWER_W'($urandom));
  endtask

  initial begin
    int wait_left;
    int taken_count;
    bit taken;
    wait_left = 0;
    taken_count = 0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        wait_left = LONG_HOLD;
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      taken = out_valid && out_ready;
      @(negedge clk);
      if (taken) begin
        taken_count++;
        if (taken_count % 37 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        wait_left = rx_burst ? 0 : $urandom_range(0, 19);
      end
    end
  end

  initial begin
    int seq;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_LOAD_A;
    in_coefficient = '0;
    in_exponent    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(OP_ADD, '0, '0);
    send_request(OP_LOAD_A, COEFF_MAX, POWER_MAX);
    send_request(OP_LOAD_A, COEFF_MIN, '0);
    send_request(OP_LOAD_B, COEFF_MAX, POWER_MAX);
    send_request(OP_LOAD_B, COEFF_MIN, '0);
    send_request(OP_ADD, '0, '0);
    send_request(OP_LOAD_A, 16'sd5, 16'd10);
    send_request(OP_LOAD_B, -16'sd5, 16'd10);
    send_request(OP_ADD, COEFF_MIN, POWER_MAX);
    send_request(OP_NONE, COEFF_MAX, POWER_MAX);
    send_request(OP_LOAD_A, 16'sd1, 16'd3);
    send_request(OP_ADD, COEFF_MAX, POWER_MAX);
    send_request(OP_LOAD_A, 16'sd1, 16'd2);
    send_request(OP_LOAD_A, 16'sd7, 16'd9);
    send_request(OP_LOAD_B, 16'sd4, 16'd5);
    send_request(OP_LOAD_B, -16'sd1, 16'd9);
    send_request(OP_ADD, '0, '0);
    send_request(OP_LOAD_B, COEFF_MIN, 16'hAAAA);
    send_request(OP_LOAD_B, COEFF_MAX, 16'h5555);
    send_request(OP_ADD, '0, '0);
    await_drain();

    seq = 0;
    while (requests_sent < REQUEST_TARGET) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      if (seq == 3 || seq == 25) begin
        play_sums(20, 20, 1'b0, 1'b1);
        tx_burst = 1'b1;
        play_sums(4, 4, 1'b0, 1'b0);
      end else begin
        play_sums(random_length(), random_length(), $urandom_range(0, 9) == 0, 1'b0);
      end
      if (seq % 9 == 8) await_drain();
      seq++;
    end
    await_drain();

    $display("Covered %0d requests with %0d adds, %0d of them after a full store dropped terms.",
             requests_sent, adds_sent, full_store_adds);
    $display("Compared %0d sum terms under random stalls on both channels.", terms_checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/spma_pkg.sv
design/spma_store.sv
design/spma_merge.sv
design/sparse_polynomial_merge_add_core.sv
bench/spma_sum_check.sv
bench/tb_top.sv
